// ----- src/mfr_pkg.sv -----
// mfr_pkg: shared types, constants and the CRC step of the frame receiver.
// Depends on nothing; the other files except mfr_ram use it by scoped names.
package mfr_pkg;

	localparam logic [7:0]  STX_V1   = 8'hFE;
	localparam logic [7:0]  STX_V2   = 8'hFD;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	// sequence table: one entry per system id
	localparam int SEQ_DEPTH = 256;
	localparam int SEQ_W     = 8;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MSGID_MATCH_ON = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_MSGID  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SYSID_MATCH_ON = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_SYSID  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COMPID_MATCH_ON = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ALLOWED_COMPID = 3'd6;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_EOF     = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_LEN,
		PH_INCOMPAT,
		PH_COMPAT,
		PH_SEQ,
		PH_SYS,
		PH_COMP,
		PH_MID0,
		PH_MID1,
		PH_MID2,
		PH_PAYLOAD,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	typedef struct packed {
		logic        filter_enable;
		logic        msgid_match_on;
		logic [23:0] allowed_msgid;
		logic        sysid_match_on;
		logic [7:0]  allowed_sysid;
		logic        compid_match_on;
		logic [7:0]  allowed_compid;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic        version;
		logic [23:0] msgid;
		logic [7:0]  sysid;
		logic [7:0]  compid;
		logic [7:0]  seq_num;
		logic [7:0]  payload_length;
		logic        crc_ok;
		logic        accepted;
		logic        seq_error;
	} res_t;

	// CRC-16/MCRF4XX, one byte, bit-serial in eight narrow steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- src/mavlink_frame_receiver.sv -----
// mavlink_frame_receiver: top level of the byte-serial frame receiver.
// Depends on mfr_pkg, mfr_parser, mfr_skid (and mfr_ram below the parser).
//
//  channel | signals                              | width | direction
//  --------+--------------------------------------+-------+----------
//  in      | in_valid, in_stall, rx_byte          | 8     | byte in
//  out     | out_valid, out_stall, kind .. seq_error | 77 | result out
//  cfg     | cfg_we, cfg_index, cfg_data          | 3+24  | write only
//
// One input word per cycle while in_stall is low; the parser does each word's
// CRC byte step and phase in the cycle it is taken, and its result (if any)
// is registered into the output register, or the skid entry while it stalls.
// in_stall is the registered skid-full flag, so the input keeps flowing
// while one result waits on a stalled output; it rises only with two waiting.
// arst_n clears the phase, header registers, CRC seed, config and the
// sequence-table valid bits; the table RAM itself needs no clearing pass.
module mavlink_frame_receiver (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic [7:0]                          payload_byte,
	output logic [7:0]                          payload_index,
	output logic                                version,
	output logic [23:0]                         msgid,
	output logic [7:0]                          sysid,
	output logic [7:0]                          compid,
	output logic [7:0]                          seq_num,
	output logic [7:0]                          payload_length,
	output logic                                crc_ok,
	output logic                                accepted,
	output logic                                seq_error,
	// configuration
	input  logic                                cfg_we,
	input  logic [mfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mfr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	mfr_pkg::cfg_t cfg_q;
	mfr_pkg::res_t push_res;
	mfr_pkg::res_t out_res;
	logic          push;
	logic          skid_full;
	logic          in_fire;

	// a word is taken whenever the skid entry is free
	assign in_stall = skid_full;
	assign in_fire  = in_valid && !skid_full;

	// config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfr_pkg::REG_FILTER_ENABLE:   cfg_q.filter_enable   <= cfg_data[0];
				mfr_pkg::REG_MSGID_MATCH_ON:  cfg_q.msgid_match_on  <= cfg_data[0];
				mfr_pkg::REG_ALLOWED_MSGID:   cfg_q.allowed_msgid   <= cfg_data[23:0];
				mfr_pkg::REG_SYSID_MATCH_ON:  cfg_q.sysid_match_on  <= cfg_data[0];
				mfr_pkg::REG_ALLOWED_SYSID:   cfg_q.allowed_sysid   <= cfg_data[7:0];
				mfr_pkg::REG_COMPID_MATCH_ON: cfg_q.compid_match_on <= cfg_data[0];
				mfr_pkg::REG_ALLOWED_COMPID:  cfg_q.allowed_compid  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mfr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (in_fire),
		.rx_byte(rx_byte),
		.cfg    (cfg_q),
		.push   (push),
		.res    (push_res)
	);

	mfr_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_res),
		.full     (skid_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_res)
	);

	assign kind           = out_res.kind;
	assign payload_byte   = out_res.payload_byte;
	assign payload_index  = out_res.payload_index;
	assign version        = out_res.version;
	assign msgid          = out_res.msgid;
	assign sysid          = out_res.sysid;
	assign compid         = out_res.compid;
	assign seq_num        = out_res.seq_num;
	assign payload_length = out_res.payload_length;
	assign crc_ok         = out_res.crc_ok;
	assign accepted       = out_res.accepted;
	assign seq_error      = out_res.seq_error;

endmodule

// ----- src/mfr_ram.sv -----
// mfr_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/mfr_parser.sv -----
// mfr_parser: frame phase tracking, header capture, running CRC and sequence check.
// Depends on mfr_pkg and mfr_ram (sequence table).
module mfr_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    rx_byte,
	input  mfr_pkg::cfg_t cfg,
	output logic          push,
	output mfr_pkg::res_t res
);

	localparam int SEQ_AW = $clog2(mfr_pkg::SEQ_DEPTH);

	mfr_pkg::phase_t phase_q, phase_nxt;

	logic        ver_q;
	logic [7:0]  len_q;
	logic [7:0]  cnt_q;
	logic [23:0] msgid_q;
	logic [7:0]  sysid_q;
	logic [7:0]  compid_q;
	logic [7:0]  seq_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q;
	logic [mfr_pkg::SEQ_DEPTH-1:0] seq_valid_q;

	logic [15:0]             crc_nxt;
	logic [mfr_pkg::SEQ_W-1:0] seq_rd;
	logic [mfr_pkg::SEQ_W-1:0] seq_exp;
	logic [7:0]              cnt_inc;
	logic                    is_stx;
	logic                    crc_ok;
	logic                    pass;
	logic                    seq_we;

	assign crc_nxt = mfr_pkg::crc_feed(crc_q, rx_byte);
	assign cnt_inc = cnt_q + 8'd1;
	assign is_stx  = (rx_byte == mfr_pkg::STX_V1) || (rx_byte == mfr_pkg::STX_V2);
	assign crc_ok  = ({rx_byte, crc_lo_q} == crc_q);
	// never-written entries read as zero
	assign seq_exp = seq_valid_q[sysid_q[SEQ_AW-1:0]] ? seq_rd : '0;

	always_comb begin
		pass = 1'b1;
		if (cfg.filter_enable) begin
			if (cfg.msgid_match_on && (msgid_q != cfg.allowed_msgid)) pass = 1'b0;
			if (cfg.sysid_match_on && (sysid_q != cfg.allowed_sysid)) pass = 1'b0;
			if (cfg.compid_match_on && (compid_q != cfg.allowed_compid)) pass = 1'b0;
		end
	end

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			mfr_pkg::PH_LEN:      phase_nxt = ver_q ? mfr_pkg::PH_INCOMPAT : mfr_pkg::PH_SEQ;
			mfr_pkg::PH_INCOMPAT: phase_nxt = mfr_pkg::PH_COMPAT;
			mfr_pkg::PH_COMPAT:   phase_nxt = mfr_pkg::PH_SEQ;
			mfr_pkg::PH_SEQ:      phase_nxt = mfr_pkg::PH_SYS;
			mfr_pkg::PH_SYS:      phase_nxt = mfr_pkg::PH_COMP;
			mfr_pkg::PH_COMP:     phase_nxt = mfr_pkg::PH_MID0;
			mfr_pkg::PH_MID0:     phase_nxt = mfr_pkg::PH_MID1;
			mfr_pkg::PH_MID1: begin
				if (ver_q) phase_nxt = mfr_pkg::PH_MID2;
				else phase_nxt = (len_q == 8'd0) ? mfr_pkg::PH_CRC_LO : mfr_pkg::PH_PAYLOAD;
			end
			mfr_pkg::PH_MID2:
				phase_nxt = (len_q == 8'd0) ? mfr_pkg::PH_CRC_LO : mfr_pkg::PH_PAYLOAD;
			mfr_pkg::PH_PAYLOAD:
				phase_nxt = (cnt_inc >= len_q) ? mfr_pkg::PH_CRC_LO : mfr_pkg::PH_PAYLOAD;
			mfr_pkg::PH_CRC_LO:   phase_nxt = mfr_pkg::PH_CRC_HI;
			mfr_pkg::PH_CRC_HI:   phase_nxt = mfr_pkg::PH_IDLE;
			default:              phase_nxt = is_stx ? mfr_pkg::PH_LEN : mfr_pkg::PH_IDLE;
		endcase
	end

	// outputs: result word and table write
	always_comb begin
		push   = 1'b0;
		seq_we = 1'b0;
		res    = '0;
		res.version        = ver_q;
		res.msgid          = msgid_q;
		res.sysid          = sysid_q;
		res.compid         = compid_q;
		res.seq_num        = seq_q;
		res.payload_length = len_q;
		case (phase_q)
			mfr_pkg::PH_PAYLOAD: begin
				push              = fire;
				res.kind          = mfr_pkg::KIND_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = cnt_q;
			end
			mfr_pkg::PH_CRC_HI: begin
				push          = fire;
				seq_we        = fire && crc_ok;
				res.kind      = mfr_pkg::KIND_EOF;
				res.crc_ok    = crc_ok;
				res.accepted  = crc_ok && pass;
				res.seq_error = crc_ok && (seq_exp != '0) && (seq_exp != seq_q);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mfr_pkg::PH_IDLE;
			ver_q       <= 1'b0;
			len_q       <= '0;
			cnt_q       <= '0;
			msgid_q     <= '0;
			sysid_q     <= '0;
			compid_q    <= '0;
			seq_q       <= '0;
			crc_q       <= mfr_pkg::CRC_SEED;
			crc_lo_q    <= '0;
			seq_valid_q <= '0;
		end else if (fire) begin
			phase_q <= phase_nxt;
			case (phase_q)
				mfr_pkg::PH_LEN: begin
					crc_q <= crc_nxt;
					len_q <= rx_byte;
				end
				mfr_pkg::PH_INCOMPAT, mfr_pkg::PH_COMPAT: crc_q <= crc_nxt;
				mfr_pkg::PH_SEQ: begin
					crc_q <= crc_nxt;
					seq_q <= rx_byte;
				end
				mfr_pkg::PH_SYS: begin
					crc_q   <= crc_nxt;
					sysid_q <= rx_byte;
				end
				mfr_pkg::PH_COMP: begin
					crc_q    <= crc_nxt;
					compid_q <= rx_byte;
				end
				mfr_pkg::PH_MID0: begin
					crc_q   <= crc_nxt;
					msgid_q <= {16'h0000, rx_byte};
				end
				mfr_pkg::PH_MID1: begin
					crc_q         <= crc_nxt;
					msgid_q[15:8] <= rx_byte;
					cnt_q         <= '0;
				end
				mfr_pkg::PH_MID2: begin
					crc_q          <= crc_nxt;
					msgid_q[23:16] <= rx_byte;
					cnt_q          <= '0;
				end
				mfr_pkg::PH_PAYLOAD: begin
					crc_q <= crc_nxt;
					cnt_q <= cnt_inc;
				end
				mfr_pkg::PH_CRC_LO: crc_lo_q <= rx_byte;
				mfr_pkg::PH_CRC_HI: begin
					if (seq_we) seq_valid_q[sysid_q[SEQ_AW-1:0]] <= 1'b1;
				end
				default: begin
					if (is_stx) begin
						ver_q    <= (rx_byte == mfr_pkg::STX_V2);
						len_q    <= '0;
						cnt_q    <= '0;
						msgid_q  <= '0;
						sysid_q  <= '0;
						compid_q <= '0;
						seq_q    <= '0;
						crc_lo_q <= '0;
						crc_q    <= mfr_pkg::CRC_SEED;
					end
				end
			endcase
		end
	end

	// read address follows the captured sysid; it is stable for several
	// words before the frame's last byte, so the registered read has settled
	mfr_ram #(
		.WIDTH(mfr_pkg::SEQ_W),
		.DEPTH(mfr_pkg::SEQ_DEPTH)
	) u_seq_ram (
		.clk  (clk),
		.we   (seq_we),
		.waddr(sysid_q[SEQ_AW-1:0]),
		.wdata(seq_q + 8'd1),
		.raddr(sysid_q[SEQ_AW-1:0]),
		.rdata(seq_rd)
	);

endmodule

// ----- src/mfr_skid.sv -----
// mfr_skid: result register plus one skid entry between parser and output channel.
// Depends on mfr_pkg (res_t).
module mfr_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mfr_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output mfr_pkg::res_t out_data
);

	logic          out_valid_q;
	mfr_pkg::res_t out_data_q;
	logic          skid_valid_q;
	mfr_pkg::res_t skid_data_q;
	logic          out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			// push and a full skid never meet: a full skid stalls the input
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) out_data_q <= skid_data_q;
			else if (push) out_data_q <= push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

// ----- src/mfr_checker.sv -----
// mfr_checker: port-level checks on the frame receiver's result channel.
// Depends on mfr_pkg; bound to mavlink_frame_receiver at the end of this file.
module mfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [7:0]  payload_byte,
	input logic [7:0]  payload_index,
	input logic        crc_ok,
	input logic        accepted,
	input logic        seq_error
);

	// held result word keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(payload_index) && $stable(kind) && $stable(crc_ok))
		else $error("stalled result changed");

	a_payload_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == mfr_pkg::KIND_PAYLOAD) |-> !crc_ok && !accepted && !seq_error)
		else $error("payload word carries frame verdict");

	a_eof_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == mfr_pkg::KIND_EOF) |-> payload_byte == 8'd0 && payload_index == 8'd0)
		else $error("end of frame word carries payload data");

	a_accept_crc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (accepted || seq_error) |-> crc_ok)
		else $error("accept or sequence flag without good CRC");

endmodule

bind mavlink_frame_receiver mfr_checker u_mfr_checker (.*);
